### hw/rtl/fnss_pkg.sv
// Shared constants and types for the four-neighbour sum stencil.
`default_nettype none
package fnss_pkg;

  localparam int GRID_WIDTH_W  = 11;
  localparam int GRID_HEIGHT_W = 16;
  localparam int ROW_W         = 16;
  localparam int COL_W         = 10;
  localparam int SUM_W         = 34;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 64;
  localparam int ADDR_W        = 3;
  localparam int APB_DATA_W    = 32;
  localparam int RES_SLOTS     = 3;

  localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST  = 11'd1024;
  localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST = 16'd1024;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic last_col;
    logic last_row;
  } pos_flags_t;

endpackage
`default_nettype wire

### hw/rtl/four_neighbour_sum_stencil_top.sv
// Top level of the four-neighbour sum stencil.
// Takes grid cells in raster order, one beat per clock when not stalled, and gives for
// each cell the sum of its in-grid up, down, left and right neighbours, tagged with row
// and column. A cell's result leaves when the cell below it arrives; cells of the last
// row leave one beat later, the final cell on its own beat, so a last-row beat releases
// up to three results and holds the input while they leave, as the output moves one
// result per clock while m_tready is high. Every other beat is taken at one per clock
// unless m_tready stalls. Stage 1 holds a beat while line data is read; stage 2 holds
// its results. The two previous rows sit in two line RAMs of MAX_WIDTH entries, each
// with two read ports; there is no clearing pass after reset. The user must write
// grid_width and grid_height over APB between frames; the block does not enforce it.
`default_nettype none
module four_neighbour_sum_stencil_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // APB configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [fnss_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [fnss_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [fnss_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                    pready,
  // input stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [fnss_pkg::IN_DATA_W-1:0]     s_tdata,  // [31:0] pixel_value
  // output stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [fnss_pkg::OUT_DATA_W-1:0]    m_tdata,  // [15:0] out_row,
                                                            // [25:16] out_col,
                                                            // [59:26] neighbour_sum
  output logic                                    m_tlast   // last_of_run
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (WW > fnss_pkg::GRID_WIDTH_W) ? WW : fnss_pkg::GRID_WIDTH_W;
  localparam int SW = fnss_pkg::SUM_W;
  localparam int RW = fnss_pkg::ROW_W;
  localparam int OW = fnss_pkg::COL_W;
  localparam int NS = fnss_pkg::RES_SLOTS;

  function automatic logic signed [SW-1:0] sx(input logic [PIXEL_BITS-1:0] v);
    sx = {{(SW - PIXEL_BITS){v[PIXEL_BITS-1]}}, v};
  endfunction

  // configuration
  logic [fnss_pkg::GRID_WIDTH_W-1:0]  grid_width;
  logic [fnss_pkg::GRID_HEIGHT_W-1:0] grid_height;
  logic                               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= fnss_pkg::GRID_WIDTH_RST;
      grid_height <= fnss_pkg::GRID_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        fnss_pkg::REG_GRID_WIDTH:  grid_width  <= pwdata[fnss_pkg::GRID_WIDTH_W-1:0];
        fnss_pkg::REG_GRID_HEIGHT: grid_height <= pwdata[fnss_pkg::GRID_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      fnss_pkg::REG_GRID_WIDTH:  prdata = fnss_pkg::APB_DATA_W'(grid_width);
      fnss_pkg::REG_GRID_HEIGHT: prdata = fnss_pkg::APB_DATA_W'(grid_height);
      default:                   prdata = '0;
    endcase
  end

  // position of the arriving beat
  logic [CW-1:0]       col_count;
  logic [RW-1:0]       row_count;
  logic [XW-1:0]       w_eff;
  logic [XW-1:0]       w_m1;
  logic [RW-1:0]       h_eff;
  logic [RW-1:0]       h_m1;
  logic [CW-1:0]       c;
  logic [RW-1:0]       r;
  fnss_pkg::pos_flags_t flags;

  always_comb begin
    if (grid_width == '0) begin
      w_eff = XW'(1);
    end else if (XW'(grid_width) > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(grid_width);
    end
    w_m1  = w_eff - XW'(1);
    h_eff = (grid_height == '0) ? RW'(1) : grid_height;
    h_m1  = h_eff - RW'(1);
    flags.last_col = XW'(col_count) >= w_m1;
    flags.last_row = row_count >= h_m1;
    c = flags.last_col ? CW'(w_m1) : col_count;
    r = flags.last_row ? h_m1 : row_count;
    flags.r_ge1 = r >= RW'(1);
    flags.r_ge2 = r >= RW'(2);
    flags.c_ge1 = XW'(c) >= XW'(1);
    flags.c_ge2 = XW'(c) >= XW'(2);
  end

  // pipeline control
  logic            accept;
  logic            s1_valid;
  logic            s1_adv;
  logic [NS-1:0]   s2_mask;
  logic            s2_free;
  logic            out_fire;

  assign m_tvalid = |s2_mask;
  assign m_tlast  = (s2_mask & (s2_mask - NS'(1))) == '0;
  assign out_fire = m_tvalid && m_tready;
  assign s2_free  = (s2_mask == '0) || (out_fire && m_tlast);
  assign s1_adv   = s1_valid && s2_free;
  assign s_tready = !rst && (!s1_valid || s2_free);
  assign accept   = s_tvalid && s_tready;

  logic [PIXEL_BITS-1:0] left_pixel;
  logic [PIXEL_BITS-1:0] left_left_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count       <= '0;
      row_count       <= '0;
      left_pixel      <= '0;
      left_left_pixel <= '0;
    end else if (accept) begin
      left_left_pixel <= left_pixel;
      left_pixel      <= s_tdata[PIXEL_BITS-1:0];
      if (flags.last_col) begin
        col_count <= '0;
        row_count <= flags.last_row ? '0 : r + RW'(1);
      end else begin
        col_count <= c + CW'(1);
        row_count <= r;
      end
    end
  end

  // line RAMs
  logic [PIXEL_BITS-1:0] older_a;
  logic [PIXEL_BITS-1:0] older_b;
  logic [PIXEL_BITS-1:0] prev_a;
  logic [PIXEL_BITS-1:0] prev_b;
  logic [CW-1:0]         s1_c;

  fnss_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_older_line (
    .clk     (clk),
    .we      (s1_adv),
    .waddr   (s1_c),
    .wdata   (prev_a),
    .re      (accept),
    .raddr_a (c),
    .raddr_b (c - CW'(1)),
    .rdata_a (older_a),
    .rdata_b (older_b)
  );

  fnss_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_previous_line (
    .clk     (clk),
    .we      (accept),
    .waddr   (c),
    .wdata   (s_tdata[PIXEL_BITS-1:0]),
    .re      (accept),
    .raddr_a (c),
    .raddr_b (c + CW'(1)),
    .rdata_a (prev_a),
    .rdata_b (prev_b)
  );

  // stage 1: beat waiting for line data
  logic [PIXEL_BITS-1:0] s1_px;
  logic [PIXEL_BITS-1:0] s1_left;
  logic [PIXEL_BITS-1:0] s1_left_left;
  logic [RW-1:0]         s1_r;
  fnss_pkg::pos_flags_t  s1_flags;
  logic                  s1_fwd_c;
  logic                  s1_fwd_cm1;
  logic [PIXEL_BITS-1:0] s1_fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px        <= s_tdata[PIXEL_BITS-1:0];
      s1_left      <= left_pixel;
      s1_left_left <= left_left_pixel;
      s1_c         <= c;
      s1_r         <= r;
      s1_flags     <= flags;
      // older line written at this very edge: the read misses it
      s1_fwd_c     <= s1_adv && (s1_c == c);
      s1_fwd_cm1   <= s1_adv && (s1_c == c - CW'(1));
      s1_fwd_data  <= prev_a;
    end
  end

  logic signed [SW-1:0] px_s;
  logic signed [SW-1:0] oc_s;
  logic signed [SW-1:0] om_s;
  logic signed [SW-1:0] pc_s;
  logic signed [SW-1:0] pn_s;
  logic signed [SW-1:0] left_s;
  logic signed [SW-1:0] ll_s;
  logic signed [SW-1:0] sum_up;
  logic signed [SW-1:0] sum_left;
  logic signed [SW-1:0] sum_last;
  logic [NS-1:0]        s1_mask;

  always_comb begin
    px_s   = sx(s1_px);
    oc_s   = s1_fwd_c ? sx(s1_fwd_data) : sx(older_a);
    om_s   = s1_fwd_cm1 ? sx(s1_fwd_data) : sx(older_b);
    pc_s   = sx(prev_a);
    pn_s   = sx(prev_b);
    left_s = sx(s1_left);
    ll_s   = sx(s1_left_left);

    sum_up = px_s
           + (s1_flags.r_ge2 ? oc_s : '0)
           + (s1_flags.c_ge1 ? om_s : '0)
           + (s1_flags.last_col ? '0 : pn_s);
    sum_left = px_s
             + (s1_flags.r_ge1 ? om_s : '0)
             + (s1_flags.c_ge2 ? ll_s : '0);
    sum_last = (s1_flags.r_ge1 ? pc_s : '0)
             + (s1_flags.c_ge1 ? left_s : '0);

    s1_mask[0] = s1_flags.r_ge1;
    s1_mask[1] = s1_flags.last_row && s1_flags.c_ge1;
    s1_mask[2] = s1_flags.last_row && s1_flags.last_col;
  end

  // stage 2: results of one beat, sent one per clock while m_tready is high
  logic [RW-1:0] s2_row [NS];
  logic [OW-1:0] s2_col [NS];
  logic [SW-1:0] s2_sum [NS];
  logic [1:0]    sel;
  logic [NS-1:0] sel_hot;

  always_comb begin
    if (s2_mask[0]) begin
      sel = 2'd0;
    end else if (s2_mask[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
    sel_hot = NS'(1) << sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_mask <= '0;
    end else if (s1_adv) begin
      s2_mask <= s1_mask;
    end else if (out_fire) begin
      s2_mask <= s2_mask & ~sel_hot;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_row[0] <= s1_r - RW'(1);
      s2_col[0] <= OW'(s1_c);
      s2_sum[0] <= sum_up;
      s2_row[1] <= s1_r;
      s2_col[1] <= OW'(s1_c - CW'(1));
      s2_sum[1] <= sum_left;
      s2_row[2] <= s1_r;
      s2_col[2] <= OW'(s1_c);
      s2_sum[2] <= sum_last;
    end
  end

  assign m_tdata = {{(fnss_pkg::OUT_DATA_W - SW - OW - RW){1'b0}},
                    s2_sum[sel], s2_col[sel], s2_row[sel]};

endmodule
`default_nettype wire

### hw/rtl/fnss_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
`default_nettype none
module fnss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire
